@@ hw/rtl/fflacc_pkg.sv @@
`timescale 1ns / 1ps

package fflacc_pkg;

    // Unpacked operand: value = m * 2^(e - 52), hidden bit at m[52], zero has m == 0
    localparam int MW = 53;
    localparam int EW = 14;
    localparam int WW = 109;

    typedef struct packed {
        logic                 s;
        logic signed [EW-1:0] e;
        logic [MW-1:0]        m;
    } op_t;

    localparam logic signed [EW-1:0] E_ZERO = -14'sd3000;

    // Unit operation codes
    localparam logic [2:0] OP_ADD  = 3'd0;
    localparam logic [2:0] OP_SUB  = 3'd1;
    localparam logic [2:0] OP_MUL  = 3'd2;
    localparam logic [2:0] OP_DIV  = 3'd3;
    localparam logic [2:0] OP_ITOF = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_VARIANT = 2'd0;
    localparam logic [1:0] CFG_ACCUM   = 2'd1;

    // Operand indexes: 0..6 scratch memory, 7 running sum, 8 and up constants
    localparam logic [4:0] R0 = 5'd0;
    localparam logic [4:0] R1 = 5'd1;
    localparam logic [4:0] R2 = 5'd2;
    localparam logic [4:0] R3 = 5'd3;
    localparam logic [4:0] R4 = 5'd4;
    localparam logic [4:0] RM = 5'd6;
    localparam logic [4:0] RS = 5'd7;
    localparam logic [4:0] CI_ZERO  = 5'd8;
    localparam logic [4:0] CI_SCALE = 5'd9;
    localparam logic [4:0] CI_LN2   = 5'd10;
    localparam logic [4:0] CI_C0A   = 5'd11;
    localparam logic [4:0] CI_C0B   = 5'd12;
    localparam logic [4:0] CI_C0C   = 5'd13;
    localparam logic [4:0] CI_C0D   = 5'd14;
    localparam logic [4:0] CI_C1A   = 5'd15;
    localparam logic [4:0] CI_C1B   = 5'd16;
    localparam logic [4:0] CI_C1C   = 5'd17;
    localparam logic [4:0] CI_C1D   = 5'd18;
    localparam logic [4:0] CI_C2I0  = 5'd19;
    localparam logic [4:0] CI_C2I1  = 5'd20;
    localparam logic [4:0] CI_C2CB  = 5'd21;
    localparam logic [4:0] CI_C2A   = 5'd22;
    localparam logic [4:0] CI_C2RN  = 5'd23;
    localparam logic [4:0] CI_C2RD  = 5'd24;

    typedef struct packed {
        logic [2:0] op;
        logic [2:0] dst;
        logic [4:0] a;
        logic [4:0] b;
        logic       dbl;
        logic       fin;
    } instr_t;

    typedef struct packed {
        logic       start;
        logic [2:0] op;
        logic       dbl;
        op_t        a;
        op_t        b;
        logic [31:0] xb;
    } fpu_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
        op_t  res;
    } fpu_sts_t;

    // Elaboration-time literal conversion, optionally rounded to single
    function automatic op_t real_to_op(input real r, input logic single);
        logic [63:0]          b;
        logic [MW-1:0]        mm;
        logic signed [EW-1:0] ee;
        logic [24:0]          r24;
        op_t                  o;
        b = $realtobits(r);
        if (b[62:0] == 63'd0)
        begin
            o.s = b[63];
            o.e = E_ZERO;
            o.m = '0;
        end
        else
        begin
            ee = $signed({3'b000, b[62:52]}) - 14'sd1023;
            mm = {1'b1, b[51:0]};
            if (single)
            begin
                r24 = {1'b0, mm[52:29]} + 25'(mm[28] & ((|mm[27:0]) | mm[29]));
                if (r24[24])
                begin
                    mm = {1'b1, 52'd0};
                    ee = ee + 14'sd1;
                end
                else
                begin
                    mm = {r24[23:0], 29'd0};
                end
            end
            o.s = b[63];
            o.e = ee;
            o.m = mm;
        end
        return o;
    endfunction

    localparam op_t K_ZERO  = real_to_op(0.0, 1'b1);
    localparam op_t K_SCALE = real_to_op(1.1920928955078125e-7, 1'b1);
    localparam op_t K_LN2   = real_to_op(0.69314718, 1'b1);
    localparam op_t K_C0A   = real_to_op(124.22551499, 1'b1);
    localparam op_t K_C0B   = real_to_op(1.498030302, 1'b1);
    localparam op_t K_C0C   = real_to_op(1.72587999, 1'b1);
    localparam op_t K_C0D   = real_to_op(0.3520887068, 1'b1);
    localparam op_t K_C1A   = real_to_op(124.2098722217282, 1'b1);
    localparam op_t K_C1B   = real_to_op(1.502704726439149, 1'b1);
    localparam op_t K_C1C   = real_to_op(1.746553042329640, 1'b1);
    localparam op_t K_C1D   = real_to_op(0.356745518976678, 1'b1);
    localparam op_t K_C2I0  = real_to_op(-0.472721975352920, 1'b1);
    localparam op_t K_C2I1  = real_to_op(0.078018528401178, 1'b1);
    localparam op_t K_C2CB  = real_to_op(-0.413356886671142, 1'b0);
    localparam op_t K_C2A   = real_to_op(125.5233166734556, 1'b1);
    localparam op_t K_C2RN  = real_to_op(-0.787757784962750, 1'b1);
    localparam op_t K_C2RD  = real_to_op(0.1781810261970705, 1'b1);

    function automatic op_t const_op(input logic [4:0] idx);
        op_t o;
        unique case (idx)
            CI_SCALE: o = K_SCALE;
            CI_LN2:   o = K_LN2;
            CI_C0A:   o = K_C0A;
            CI_C0B:   o = K_C0B;
            CI_C0C:   o = K_C0C;
            CI_C0D:   o = K_C0D;
            CI_C1A:   o = K_C1A;
            CI_C1B:   o = K_C1B;
            CI_C1C:   o = K_C1C;
            CI_C1D:   o = K_C1D;
            CI_C2I0:  o = K_C2I0;
            CI_C2I1:  o = K_C2I1;
            CI_C2CB:  o = K_C2CB;
            CI_C2A:   o = K_C2A;
            CI_C2RN:  o = K_C2RN;
            CI_C2RD:  o = K_C2RD;
            default:  o = K_ZERO;
        endcase
        return o;
    endfunction

    function automatic instr_t mk(input logic [2:0] op, input logic [4:0] dst,
                                  input logic [4:0] a, input logic [4:0] b,
                                  input logic dbl, input logic fin);
        instr_t i;
        i.op  = op;
        i.dst = dst[2:0];
        i.a   = a;
        i.b   = b;
        i.dbl = dbl;
        i.fin = fin;
        return i;
    endfunction

    // Microprograms per coefficient set; the result lands in R0
    function automatic instr_t prog(input logic [1:0] v, input logic [4:0] pc);
        instr_t i;
        i = mk(OP_ADD, R0, R0, CI_ZERO, 1'b0, 1'b1);
        if (v == 2'd0)
        begin
            unique case (pc)
                5'd0:  i = mk(OP_ITOF, R0, R0, R0, 1'b0, 1'b0);
                5'd1:  i = mk(OP_MUL, R0, R0, CI_SCALE, 1'b0, 1'b0);
                5'd2:  i = mk(OP_MUL, R0, R0, CI_LN2, 1'b0, 1'b0);
                5'd3:  i = mk(OP_MUL, R1, CI_C0A, CI_LN2, 1'b0, 1'b0);
                5'd4:  i = mk(OP_SUB, R0, R0, R1, 1'b0, 1'b0);
                5'd5:  i = mk(OP_MUL, R1, CI_C0B, CI_LN2, 1'b0, 1'b0);
                5'd6:  i = mk(OP_MUL, R1, R1, RM, 1'b0, 1'b0);
                5'd7:  i = mk(OP_SUB, R0, R0, R1, 1'b0, 1'b0);
                5'd8:  i = mk(OP_MUL, R1, CI_C0C, CI_LN2, 1'b0, 1'b0);
                5'd9:  i = mk(OP_ADD, R2, CI_C0D, RM, 1'b0, 1'b0);
                5'd10: i = mk(OP_DIV, R1, R1, R2, 1'b0, 1'b0);
                default: i = mk(OP_SUB, R0, R0, R1, 1'b0, 1'b1);
            endcase
        end
        else if (v == 2'd1)
        begin
            unique case (pc)
                5'd0:  i = mk(OP_MUL, R1, CI_SCALE, CI_LN2, 1'b0, 1'b0);
                5'd1:  i = mk(OP_ITOF, R0, R0, R0, 1'b1, 1'b0);
                5'd2:  i = mk(OP_MUL, R0, R0, R1, 1'b1, 1'b0);
                5'd3:  i = mk(OP_ADD, R0, R0, CI_ZERO, 1'b0, 1'b0);
                5'd4:  i = mk(OP_MUL, R1, CI_C1A, CI_LN2, 1'b0, 1'b0);
                5'd5:  i = mk(OP_SUB, R0, R0, R1, 1'b0, 1'b0);
                5'd6:  i = mk(OP_MUL, R1, CI_C1B, CI_LN2, 1'b0, 1'b0);
                5'd7:  i = mk(OP_MUL, R1, R1, RM, 1'b0, 1'b0);
                5'd8:  i = mk(OP_SUB, R0, R0, R1, 1'b0, 1'b0);
                5'd9:  i = mk(OP_MUL, R1, CI_C1C, CI_LN2, 1'b0, 1'b0);
                5'd10: i = mk(OP_ADD, R2, CI_C1D, RM, 1'b0, 1'b0);
                5'd11: i = mk(OP_DIV, R1, R1, R2, 1'b0, 1'b0);
                default: i = mk(OP_SUB, R0, R0, R1, 1'b0, 1'b1);
            endcase
        end
        else
        begin
            unique case (pc)
                5'd0:  i = mk(OP_MUL, R1, CI_SCALE, CI_LN2, 1'b0, 1'b0);
                5'd1:  i = mk(OP_ITOF, R0, R0, R0, 1'b0, 1'b0);
                5'd2:  i = mk(OP_MUL, R0, R0, R1, 1'b0, 1'b0);
                5'd3:  i = mk(OP_MUL, R2, CI_C2I1, RM, 1'b0, 1'b0);
                5'd4:  i = mk(OP_ADD, R2, CI_C2I0, R2, 1'b0, 1'b0);
                5'd5:  i = mk(OP_MUL, R2, RM, R2, 1'b0, 1'b0);
                5'd6:  i = mk(OP_ADD, R2, CI_C2CB, R2, 1'b1, 1'b0);
                5'd7:  i = mk(OP_MUL, R2, RM, R2, 1'b1, 1'b0);
                5'd8:  i = mk(OP_MUL, R2, R2, CI_LN2, 1'b1, 1'b0);
                5'd9:  i = mk(OP_MUL, R3, CI_C2RN, CI_LN2, 1'b0, 1'b0);
                5'd10: i = mk(OP_ADD, R4, CI_C2RD, RM, 1'b0, 1'b0);
                5'd11: i = mk(OP_DIV, R3, R3, R4, 1'b0, 1'b0);
                5'd12: i = mk(OP_MUL, R1, CI_C2A, CI_LN2, 1'b0, 1'b0);
                5'd13: i = mk(OP_SUB, R0, R0, R1, 1'b0, 1'b0);
                5'd14: i = mk(OP_ADD, R0, R0, R2, 1'b1, 1'b0);
                5'd15: i = mk(OP_ADD, R0, R0, R3, 1'b1, 1'b0);
                default: i = mk(OP_ADD, R0, R0, CI_ZERO, 1'b0, 1'b1);
            endcase
        end
        return i;
    endfunction

    // Pack a single-rounded operand into IEEE single bits
    function automatic logic [31:0] to_single(input op_t o);
        logic [EW-1:0] be;
        be = o.e + 14'sd127;
        if (o.m == '0)
        begin
            return {o.s, 31'd0};
        end
        return {o.s, be[7:0], o.m[51:29]};
    endfunction

endpackage

@@ hw/rtl/fflacc_fpu.sv @@
`timescale 1ns / 1ps

module fflacc_fpu
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  fflacc_pkg::fpu_cmd_t cmd,
    output fflacc_pkg::fpu_sts_t sts
);

    localparam logic [2:0] F_IDLE  = 3'd0;
    localparam logic [2:0] F_ADD   = 3'd1;
    localparam logic [2:0] F_MUL   = 3'd2;
    localparam logic [2:0] F_DIV   = 3'd3;
    localparam logic [2:0] F_NORM  = 3'd4;
    localparam logic [2:0] F_ROUND = 3'd5;

    localparam int WW = fflacc_pkg::WW;
    localparam int MW = fflacc_pkg::MW;
    localparam int EW = fflacc_pkg::EW;

    logic [2:0]           st_reg;
    logic [WW-1:0]        wm_reg;
    logic [WW-1:0]        sm_reg;
    logic                 sub_reg;
    logic                 stk_reg;
    logic signed [EW-1:0] ex_reg;
    logic                 sg_reg;
    logic                 zs_reg;
    logic                 dbl_reg;
    logic [5:0]           cnt_reg;
    logic [MW-1:0]        ma_reg;
    logic [MW-1:0]        mb_reg;
    logic [MW:0]          rem_reg;
    logic [55:0]          q_reg;
    fflacc_pkg::op_t      res_reg;
    logic                 done_reg;

    // Alignment for add and subtract
    logic                 a_big;
    logic                 sb_eff;
    fflacc_pkg::op_t      big;
    fflacc_pkg::op_t      sml;
    logic                 sml_s;
    logic [EW-1:0]        dsh;
    logic [WW-1:0]        wsml;
    logic [WW-1:0]        smask;
    logic [WW-1:0]        smj;

    always_comb
    begin
        sb_eff = cmd.b.s ^ (cmd.op == fflacc_pkg::OP_SUB);
        a_big  = ($signed(cmd.a.e) > $signed(cmd.b.e)) ||
                 ((cmd.a.e == cmd.b.e) && (cmd.a.m >= cmd.b.m));
        big    = a_big ? cmd.a : cmd.b;
        sml    = a_big ? cmd.b : cmd.a;
        big.s  = a_big ? cmd.a.s : sb_eff;
        sml_s  = a_big ? sb_eff : cmd.a.s;
        dsh    = big.e - sml.e;
        wsml   = {2'b00, sml.m, 54'd0};
        smask  = ({{(WW-1){1'b0}}, 1'b1} << dsh) - {{(WW-1){1'b0}}, 1'b1};
        smj    = (wsml >> dsh) | {{(WW-1){1'b0}}, |(wsml & smask)};
    end

    // Partial product for the multiplier
    logic [26:0]   pa;
    logic [26:0]   pb;
    logic [53:0]   pp;
    logic [WW-1:0] ppw;

    always_comb
    begin
        pa  = cnt_reg[0] ? {1'b0, ma_reg[52:27]} : ma_reg[26:0];
        pb  = cnt_reg[1] ? {1'b0, mb_reg[52:27]} : mb_reg[26:0];
        pp  = pa * pb;
        ppw = {{(WW-54){1'b0}}, pp} << 2;
        if (cnt_reg[1:0] == 2'd3)
        begin
            ppw = ppw << 54;
        end
        else if (cnt_reg[1:0] != 2'd0)
        begin
            ppw = ppw << 27;
        end
    end

    // Divider step
    logic          ge;
    logic [MW:0]   rd;
    logic [55:0]   q_n;

    always_comb
    begin
        ge  = rem_reg >= {1'b0, mb_reg};
        rd  = ge ? (rem_reg - {1'b0, mb_reg}) : rem_reg;
        q_n = {q_reg[54:0], ge};
    end

    // Round to nearest even at 53 or 24 bits
    logic            up53;
    logic            up24;
    logic [MW:0]     inc53;
    logic [24:0]     inc24;
    fflacc_pkg::op_t rnd;

    always_comb
    begin
        up53  = wm_reg[54] & ((|wm_reg[53:0]) | stk_reg | wm_reg[55]);
        up24  = wm_reg[83] & ((|wm_reg[82:0]) | stk_reg | wm_reg[84]);
        inc53 = {1'b0, wm_reg[107:55]} + {{MW{1'b0}}, up53};
        inc24 = {1'b0, wm_reg[107:84]} + {24'd0, up24};
        rnd.s = sg_reg;
        rnd.e = ex_reg;
        if (dbl_reg)
        begin
            rnd.m = inc53[MW-1:0];
            if (inc53[MW])
            begin
                rnd.m = {1'b1, {(MW-1){1'b0}}};
                rnd.e = ex_reg + 14'sd1;
            end
        end
        else
        begin
            rnd.m = {inc24[23:0], 29'd0};
            if (inc24[24])
            begin
                rnd.m = {1'b1, {(MW-1){1'b0}}};
                rnd.e = ex_reg + 14'sd1;
            end
        end
    end

    // Sequence the shared unit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= F_IDLE;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (st_reg)
                F_IDLE:
                begin
                    if (cmd.start)
                    begin
                        cnt_reg <= '0;
                        if (cmd.op == fflacc_pkg::OP_MUL)
                        begin
                            st_reg <= F_MUL;
                        end
                        else if (cmd.op == fflacc_pkg::OP_DIV)
                        begin
                            st_reg <= F_DIV;
                        end
                        else if (cmd.op == fflacc_pkg::OP_ITOF)
                        begin
                            st_reg <= F_NORM;
                        end
                        else
                        begin
                            st_reg <= F_ADD;
                        end
                    end
                end
                F_ADD:
                begin
                    st_reg <= F_NORM;
                end
                F_MUL:
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg[1:0] == 2'd3)
                    begin
                        st_reg <= F_NORM;
                    end
                end
                F_DIV:
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd55)
                    begin
                        st_reg <= F_NORM;
                    end
                end
                F_NORM:
                begin
                    if (wm_reg == '0)
                    begin
                        done_reg <= 1'b1;
                        st_reg   <= F_IDLE;
                    end
                    else if (wm_reg[108] || wm_reg[107])
                    begin
                        st_reg <= F_ROUND;
                    end
                end
                F_ROUND:
                begin
                    done_reg <= 1'b1;
                    st_reg   <= F_IDLE;
                end
                default:
                begin
                    st_reg <= F_IDLE;
                end
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        unique case (st_reg)
            F_IDLE:
            begin
                dbl_reg <= cmd.dbl;
                stk_reg <= 1'b0;
                if (cmd.op == fflacc_pkg::OP_MUL)
                begin
                    wm_reg <= '0;
                    ma_reg <= cmd.a.m;
                    mb_reg <= cmd.b.m;
                    sg_reg <= cmd.a.s ^ cmd.b.s;
                    zs_reg <= cmd.a.s ^ cmd.b.s;
                    ex_reg <= cmd.a.e + cmd.b.e + 14'sd1;
                end
                else if (cmd.op == fflacc_pkg::OP_DIV)
                begin
                    rem_reg <= {1'b0, cmd.a.m};
                    mb_reg  <= cmd.b.m;
                    q_reg   <= '0;
                    sg_reg  <= cmd.a.s ^ cmd.b.s;
                    zs_reg  <= cmd.a.s ^ cmd.b.s;
                    ex_reg  <= cmd.a.e - cmd.b.e;
                end
                else if (cmd.op == fflacc_pkg::OP_ITOF)
                begin
                    wm_reg <= {1'b0, cmd.xb, 76'd0};
                    sg_reg <= 1'b0;
                    zs_reg <= 1'b0;
                    ex_reg <= 14'sd31;
                end
                else
                begin
                    wm_reg  <= {2'b00, big.m, 54'd0};
                    sm_reg  <= smj;
                    sub_reg <= big.s ^ sml_s;
                    sg_reg  <= big.s;
                    zs_reg  <= big.s & sml_s;
                    ex_reg  <= big.e + 14'sd1;
                end
            end
            F_ADD:
            begin
                wm_reg <= sub_reg ? (wm_reg - sm_reg) : (wm_reg + sm_reg);
            end
            F_MUL:
            begin
                wm_reg <= wm_reg + ppw;
            end
            F_DIV:
            begin
                rem_reg <= {rd[MW-1:0], 1'b0};
                q_reg   <= q_n;
                if (cnt_reg == 6'd55)
                begin
                    wm_reg  <= {1'b0, q_n, 52'd0};
                    stk_reg <= |rd;
                end
            end
            F_NORM:
            begin
                if (wm_reg == '0)
                begin
                    res_reg.s <= zs_reg;
                    res_reg.e <= fflacc_pkg::E_ZERO;
                    res_reg.m <= '0;
                end
                else if (wm_reg[108])
                begin
                    wm_reg  <= wm_reg >> 1;
                    stk_reg <= stk_reg | wm_reg[0];
                    ex_reg  <= ex_reg + 14'sd1;
                end
                else if (!wm_reg[107])
                begin
                    wm_reg <= wm_reg << 1;
                    ex_reg <= ex_reg - 14'sd1;
                end
            end
            F_ROUND:
            begin
                res_reg <= rnd;
            end
            default:
            begin
                res_reg <= rnd;
            end
        endcase
    end

    assign sts.busy = (st_reg != F_IDLE);
    assign sts.done = done_reg;
    assign sts.res  = res_reg;

endmodule

@@ hw/rtl/fast_float_log_accumulate.sv @@
`timescale 1ns / 1ps
// Steps per beat: 12 to 17 unit steps by coefficient set, plus one sum step when accumulating;
// each step passes through fetch, issue and a wait for the unit's done. A step takes longer
// when a subtraction cancels deeply. The input takes no new beat until the block is idle again.
// Unit work: add/sub aligns, adds and normalizes; multiply sums four 27x27 partial products,
// divide makes one quotient bit a cycle, int-to-float runs the one-bit normalizer.
// Reset: asynchronous, active low; variant 2, accumulate off, running sum +0, no beat held.
module fast_float_log_accumulate
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] x_bits
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] log_bits
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [1:0]  cfg_data
);

    localparam logic [2:0] T_IDLE  = 3'd0;
    localparam logic [2:0] T_FETCH = 3'd1;
    localparam logic [2:0] T_ISSUE = 3'd2;
    localparam logic [2:0] T_WAIT  = 3'd3;
    localparam logic [2:0] T_EMIT  = 3'd4;

    logic [2:0]          state_reg;
    logic [1:0]          variant_reg;
    logic                accum_reg;
    logic [4:0]          pc_reg;
    logic [1:0]          vsel_reg;
    logic                amode_reg;
    logic                accph_reg;
    logic [31:0]         xb_reg;
    logic                last_reg;
    fflacc_pkg::op_t     sum_reg;
    logic [31:0]         pend_bits_reg;
    logic                pend_last_reg;
    logic [31:0]         out_data_reg;
    logic                out_last_reg;
    logic                out_valid_reg;
    fflacc_pkg::op_t     rda_reg;
    fflacc_pkg::op_t     rdb_reg;
    fflacc_pkg::op_t     mem [8];

    fflacc_pkg::instr_t  instr;
    fflacc_pkg::fpu_cmd_t cmd;
    fflacc_pkg::fpu_sts_t sts;
    logic                s_acc;
    logic                out_free;
    logic                mem_we;
    logic [2:0]          mem_waddr;
    fflacc_pkg::op_t     mem_wdata;
    fflacc_pkg::op_t     m_op;

    function automatic fflacc_pkg::op_t pick(input logic [4:0] idx, input fflacc_pkg::op_t rd,
                                             input fflacc_pkg::op_t sum);
        if (idx >= fflacc_pkg::CI_ZERO)
        begin
            return fflacc_pkg::const_op(idx);
        end
        if (idx == fflacc_pkg::RS)
        begin
            return sum;
        end
        return rd;
    endfunction

    assign s_tready = (state_reg == T_IDLE);
    assign s_acc    = s_tvalid & s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    // Pick the running step: microprogram, then the sum update
    always_comb
    begin
        if (accph_reg)
        begin
            instr = fflacc_pkg::mk(fflacc_pkg::OP_ADD, fflacc_pkg::RS, fflacc_pkg::RS,
                                   fflacc_pkg::R0, 1'b0, 1'b1);
        end
        else
        begin
            instr = fflacc_pkg::prog(vsel_reg, pc_reg);
        end
        cmd.start = (state_reg == T_ISSUE);
        cmd.op    = instr.op;
        cmd.dbl   = instr.dbl;
        cmd.a     = pick(instr.a, rda_reg, sum_reg);
        cmd.b     = pick(instr.b, rdb_reg, sum_reg);
        cmd.xb    = xb_reg;
    end

    fflacc_fpu u_fpu
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .sts   (sts)
    );

    // Scratch write port: mantissa operand on accept, step results otherwise
    always_comb
    begin
        m_op.s    = 1'b0;
        m_op.e    = -14'sd1;
        m_op.m    = {1'b1, s_tdata[22:0], 29'd0};
        mem_we    = 1'b0;
        mem_waddr = fflacc_pkg::RM[2:0];
        mem_wdata = m_op;
        if (s_acc)
        begin
            mem_we = 1'b1;
        end
        else if ((state_reg == T_WAIT) && sts.done && !accph_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = instr.dst;
            mem_wdata = sts.res;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (state_reg == T_FETCH)
        begin
            rda_reg <= mem[instr.a[2:0]];
            rdb_reg <= mem[instr.b[2:0]];
        end
    end

    // Hold configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            variant_reg <= 2'd2;
            accum_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == fflacc_pkg::CFG_VARIANT)
            begin
                variant_reg <= cfg_data;
            end
            else if (cfg_index == fflacc_pkg::CFG_ACCUM)
            begin
                accum_reg <= cfg_data[0];
            end
        end
    end

    // Sequence the steps of one beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            pc_reg        <= '0;
            accph_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            sum_reg       <= fflacc_pkg::K_ZERO;
        end
        else
        begin
            if (out_valid_reg && m_tready && (state_reg != T_EMIT))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                T_IDLE:
                begin
                    if (s_acc)
                    begin
                        xb_reg    <= s_tdata;
                        last_reg  <= s_tlast;
                        vsel_reg  <= (variant_reg == 2'd3) ? 2'd2 : variant_reg;
                        amode_reg <= accum_reg;
                        accph_reg <= 1'b0;
                        pc_reg    <= '0;
                        state_reg <= T_FETCH;
                    end
                end
                T_FETCH:
                begin
                    state_reg <= T_ISSUE;
                end
                T_ISSUE:
                begin
                    state_reg <= T_WAIT;
                end
                T_WAIT:
                begin
                    if (sts.done)
                    begin
                        if (accph_reg)
                        begin
                            sum_reg       <= last_reg ? fflacc_pkg::K_ZERO : sts.res;
                            pend_bits_reg <= fflacc_pkg::to_single(sts.res);
                            pend_last_reg <= 1'b1;
                            state_reg     <= last_reg ? T_EMIT : T_IDLE;
                        end
                        else if (!instr.fin)
                        begin
                            pc_reg    <= pc_reg + 5'd1;
                            state_reg <= T_FETCH;
                        end
                        else if (amode_reg)
                        begin
                            accph_reg <= 1'b1;
                            state_reg <= T_FETCH;
                        end
                        else
                        begin
                            pend_bits_reg <= fflacc_pkg::to_single(sts.res);
                            pend_last_reg <= last_reg;
                            state_reg     <= T_EMIT;
                        end
                    end
                end
                T_EMIT:
                begin
                    if (out_free)
                    begin
                        out_data_reg  <= pend_bits_reg;
                        out_last_reg  <= pend_last_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= T_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= T_IDLE;
                end
            endcase
        end
    end

    // Checks
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |-> !sts.busy)
        else $error("unit started while busy");

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !sts.busy)
        else $error("input ready while unit busy");

    a_sum_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == T_WAIT && sts.done && accph_reg && last_reg) |=> (sum_reg.m == '0))
        else $error("running sum not cleared after run end");

    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == T_EMIT))
        else $error("result loaded outside emit");

endmodule

@@ test/fast_float_log_accumulate_tb.sv @@
`timescale 1ns / 1ps

module fast_float_log_accumulate_tb;

    localparam logic [1:0] CFG_SPARE = 2'd3;   // index outside the register map
    localparam logic [1:0] SET_RATIONAL = 2'd0;
    localparam logic [1:0] SET_REFINED  = 2'd1;
    localparam logic [1:0] SET_CUBIC    = 2'd2;
    localparam logic [1:0] SET_SPARE    = 2'd3;
    localparam int SETTLE_CYCLES = 400;
    localparam int CYCLE_LIMIT   = 4000000;

    // Bit-accurate single-precision log model with the running sum
    class log_scoreboard;
        logic [31:0] log_q[$];
        bit          last_q[$];
        logic [1:0]  coef_set;
        bit          summing;
        logic [31:0] sum_bits;
        int          errors;

        function new();
            coef_set = SET_CUBIC;
            summing  = 1'b0;
            sum_bits = 32'd0;
            errors   = 0;
        endfunction

        // Round a double to single bits, nearest even
        static function logic [31:0] to_f32(real r);
            logic [63:0] b;
            logic [24:0] q;
            int          ee;
            b = $realtobits(r);
            if (b[62:52] == 11'd0)
                return {b[63], 31'd0};
            q  = {2'b01, b[51:29]} + 25'(b[28] & ((|b[27:0]) | b[29]));
            ee = int'(b[62:52]) - 1023 + 127;
            if (q[24])
            begin
                ee = ee + 1;
                q  = q >> 1;
            end
            return {b[63], 8'(ee), q[22:0]};
        endfunction

        static function real from_f32(logic [31:0] s);
            if (s[30:0] == 31'd0)
                return $bitstoreal({s[31], 63'd0});
            return $bitstoreal({s[31], 11'(int'(s[30:23]) - 127 + 1023), s[22:0], 29'd0});
        endfunction

        static function real rs(real r);
            return from_f32(to_f32(r));
        endfunction

        static function real ln_approx(logic [31:0] xb, logic [1:0] sel);
            real m, ln2, scale, ix, t, sc, inner, cubic, rat, acc;
            m     = from_f32({9'h07E, xb[22:0]});
            ln2   = rs(0.69314718);
            scale = rs(1.1920928955078125e-7);
            ix    = real'(longint'({32'd0, xb}));
            if (sel == SET_RATIONAL)
            begin
                t = rs(rs(rs(ix) * scale) * ln2);
                t = rs(t - rs(rs(124.22551499) * ln2));
                t = rs(t - rs(rs(rs(1.498030302) * ln2) * m));
                t = rs(t - rs(rs(rs(1.72587999) * ln2) / rs(rs(0.3520887068) + m)));
                return t;
            end
            sc = rs(scale * ln2);
            if (sel == SET_REFINED)
            begin
                // scaling product taken in double, then rounded once
                t = rs(ix * sc);
                t = rs(t - rs(rs(124.2098722217282) * ln2));
                t = rs(t - rs(rs(rs(1.502704726439149) * ln2) * m));
                t = rs(t - rs(rs(rs(1.746553042329640) * ln2)
                              / rs(rs(0.356745518976678) + m)));
                return t;
            end
            t     = rs(rs(ix) * sc);
            inner = rs(rs(-0.472721975352920) + rs(rs(0.078018528401178) * m));
            inner = rs(m * inner);
            cubic = m * (-0.413356886671142 + inner);
            cubic = cubic * ln2;
            rat   = rs(rs(rs(-0.787757784962750) * ln2) / rs(rs(0.1781810261970705) + m));
            acc   = rs(t - rs(rs(125.5233166734556) * ln2)) + cubic;
            acc   = acc + rat;
            return rs(acc);
        endfunction

        function void write_reg(logic [1:0] idx, logic [1:0] d);
            if (idx == fflacc_pkg::CFG_VARIANT)
                coef_set = d;
            else if (idx == fflacc_pkg::CFG_ACCUM)
                summing = d[0];
        endfunction

        function void note_input(logic [31:0] xb, bit lst);
            logic [1:0]  sel;
            logic [31:0] v;
            sel = (coef_set == SET_SPARE) ? SET_CUBIC : coef_set;
            v   = to_f32(ln_approx(xb, sel));
            if (!summing)
            begin
                log_q.push_back(v);
                last_q.push_back(lst);
                return;
            end
            sum_bits = to_f32(from_f32(sum_bits) + from_f32(v));
            if (lst)
            begin
                log_q.push_back(sum_bits);
                last_q.push_back(1'b1);
                sum_bits = 32'd0;
            end
        endfunction

        function void check_result(logic [31:0] d, bit lst);
            logic [31:0] ed;
            bit          el;
            if (log_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected beat: log %h last %0d", d, lst);
                return;
            end
            ed = log_q.pop_front();
            el = last_q.pop_front();
            if (ed !== d || el !== lst)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected log %h last %0d, got log %h last %0d",
                             ed, el, d, lst);
            end
        endfunction

        function int pending();
            return log_q.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [1:0]  cfg_data;

    log_scoreboard sb;
    bit            calm;
    int            cycles;

    fast_float_log_accumulate i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Bound the run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL fast_float_log_accumulate");
            $finish;
        end
    end

    // Check every result beat
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tlast);
    end

    // Stall the result side at random
    initial
    begin : result_stall
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = calm ? 0 : $urandom_range(0, 14);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    task automatic send_beat(logic [31:0] xb, bit lst);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= xb;
        s_tlast  <= lst;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_input(xb, lst);
    endtask

    // Hold input until all results are back and the block is idle again
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0 || !s_tready)
            @(posedge clk);
        @(posedge clk);
    endtask

    // Write a register once the block is idle
    task automatic write_cfg(logic [1:0] idx, logic [1:0] d);
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        sb.write_reg(idx, d);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] pick_x();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom;
            4, 5, 6, 7: return {1'b0, 8'($urandom_range(1, 254)), 23'($urandom)};
            8:
            begin
                case ($urandom_range(0, 5))
                    0: return 32'h0000_0000;
                    1: return 32'h8000_0000;
                    2: return 32'h7F80_0000;
                    3: return 32'hFF80_0000;
                    4: return 32'h7FC0_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: return {$urandom_range(0, 1) == 1, 8'd0, 23'($urandom)};
        endcase
    endfunction

    initial
    begin : stimulus
        logic [31:0] edge_x [8];
        int          phase;
        int          n;
        int          run_len;
        clk       = 1'b0;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = 32'd0;
        s_tlast   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = 2'd0;
        cfg_data  = 2'd0;
        calm      = 1'b0;
        cycles    = 0;
        sb        = new();
        edge_x    = '{32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'h7F80_0000,
                      32'h7FC0_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h007F_FFFF};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Field extremes with the reset coefficient set
        for (int i = 0; i < 8; i++)
            send_beat(edge_x[i], i[0]);
        // Remaining coefficient sets, spare code included
        write_cfg(fflacc_pkg::CFG_VARIANT, SET_RATIONAL);
        for (int i = 0; i < 4; i++)
            send_beat(edge_x[i * 2 + 1], i[0]);
        write_cfg(fflacc_pkg::CFG_VARIANT, SET_REFINED);
        for (int i = 0; i < 4; i++)
            send_beat(edge_x[i * 2], i[0]);
        write_cfg(CFG_SPARE, 2'd0);
        write_cfg(fflacc_pkg::CFG_VARIANT, SET_SPARE);
        send_beat(32'h4000_0000, 1'b0);
        send_beat(32'h3F00_0000, 1'b1);
        // Run interrupted by turning summing off, then resumed
        write_cfg(fflacc_pkg::CFG_ACCUM, 2'd1);
        send_beat(32'h4120_0000, 1'b0);
        send_beat(32'h3DCC_CCCD, 1'b0);
        write_cfg(fflacc_pkg::CFG_ACCUM, 2'd0);
        send_beat(32'h42C8_0000, 1'b1);
        write_cfg(fflacc_pkg::CFG_ACCUM, 2'd1);
        send_beat(32'h7F7F_FFFF, 1'b1);

        // Random phases over all settings
        for (phase = 0; phase < 12; phase++)
        begin
            write_cfg(fflacc_pkg::CFG_VARIANT, 2'($urandom_range(0, 3)));
            write_cfg(fflacc_pkg::CFG_ACCUM, 2'($urandom_range(0, 1)));
            calm = ($urandom_range(0, 3) == 0);
            n = 0;
            while (n < 85)
            begin
                if (sb.summing)
                begin
                    run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 20)
                                                          : $urandom_range(1, 6);
                    for (int k = 0; k < run_len; k++)
                        send_beat(pick_x(), k == run_len - 1);
                    n += run_len;
                end
                else
                begin
                    send_beat(pick_x(), $urandom_range(0, 1) == 1);
                    n++;
                end
                if (phase == 5 && n > 40 && n < 46)
                    drain();
            end
        end

        // Wait for the tail
        s_tvalid <= 1'b0;
        calm = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASS fast_float_log_accumulate");
        else
            $display("FAIL fast_float_log_accumulate");
        $finish;
    end

endmodule
